### hw/rtl/vtns_pkg.sv
// Shared constants, codes and sizing helpers for the vertex table search unit.
package vtns_pkg;

    localparam int MAX_SIDE_DEF    = 16;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int RADIUS_W    = 15;
    localparam int STATUS_W    = 2;
    localparam int SIDE_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int INDEX_SPAN  = 1 << INDEX_W;

    // command kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVE_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INIT     = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    // operations handed from front to back
    typedef enum logic [2:0] {
        OP_REPLY,
        OP_INIT,
        OP_LOAD,
        OP_READ,
        OP_MOVE,
        OP_MOVE_ALL,
        OP_FIND
    } op_t;

    // entries reachable through an 8-bit index
    function automatic int table_depth(input int max_side);
        int sq;
        sq = max_side * max_side;
        return (sq > INDEX_SPAN) ? INDEX_SPAN : sq;
    endfunction

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // flat width of one queued command
    function automatic int cmd_width(input int coord_w, input int addr_w);
        return $bits(op_t) + STATUS_W + 2 * addr_w + 2 * coord_w + RADIUS_W;
    endfunction

endpackage

### hw/rtl/vtns_front.sv
// Front end: configuration registers, readiness flag and command classification.
module vtns_front #(
    parameter int MAX_SIDE    = vtns_pkg::MAX_SIDE_DEF,
    parameter int COORD_WIDTH = vtns_pkg::COORD_WIDTH_DEF,
    localparam int DEPTH      = vtns_pkg::table_depth(MAX_SIDE),
    localparam int AW         = vtns_pkg::addr_width(DEPTH),
    localparam int CMD_W      = vtns_pkg::cmd_width(COORD_WIDTH, AW)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [vtns_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vtns_pkg::SIDE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [vtns_pkg::KIND_W-1:0]         kind,
    input  logic [vtns_pkg::INDEX_W-1:0]        vertex_index,
    input  logic signed [COORD_WIDTH-1:0]       coord_x,
    input  logic signed [COORD_WIDTH-1:0]       coord_y,
    input  logic [vtns_pkg::RADIUS_W-1:0]       search_radius,
    output logic                                push_valid,
    input  logic                                push_ready,
    output logic [CMD_W-1:0]                    push_data
);
    import vtns_pkg::*;

    typedef struct packed {
        op_t                           op;
        logic [STATUS_W-1:0]           status;
        logic [AW-1:0]                 first;
        logic [AW-1:0]                 last;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic [RADIUS_W-1:0]           radius;
    } cmd_t;

    logic [SIDE_W-1:0] cols_reg;
    logic [SIDE_W-1:0] rows_reg;
    logic              ready_reg;
    logic [7:0]        cols_c;
    logic [7:0]        rows_c;
    logic [15:0]       prod;
    logic [INDEX_W:0]  used_count;
    logic [AW-1:0]     last_addr;
    logic              idx_ok;
    logic              accept;
    cmd_t              cmd;

    // zero acts as one, above the side limit acts as the limit
    function automatic logic [7:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [7:0] r;
        if (v == '0)
        begin
            r = 8'd1;
        end
        else if (int'(v) > MAX_SIDE)
        begin
            r = 8'(MAX_SIDE);
        end
        else
        begin
            r = 8'(v);
        end
        return r;
    endfunction

    assign cols_c     = clamp_side(cols_reg);
    assign rows_c     = clamp_side(rows_reg);
    assign prod       = cols_c * rows_c;
    assign used_count = (int'(prod) > DEPTH) ? (INDEX_W + 1)'(DEPTH) : (INDEX_W + 1)'(prod);
    assign last_addr  = AW'(used_count - (INDEX_W + 1)'(1));
    assign idx_ok     = {1'b0, vertex_index} < used_count;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        cmd.op     = OP_REPLY;
        cmd.status = ST_OK;
        cmd.first  = AW'(vertex_index);
        cmd.last   = AW'(vertex_index);
        cmd.cx     = coord_x;
        cmd.cy     = coord_y;
        cmd.radius = search_radius;
        priority if (kind == KIND_INIT)
        begin
            cmd.op = OP_INIT;
        end
        else if (kind <= KIND_FIND && !ready_reg)
        begin
            cmd.status = ST_NOT_READY;
        end
        else
        begin
            unique case (kind)
                KIND_LOAD, KIND_READ, KIND_MOVE:
                begin
                    if (!idx_ok)
                    begin
                        cmd.status = ST_RANGE;
                    end
                    else if (kind == KIND_LOAD)
                    begin
                        cmd.op = OP_LOAD;
                    end
                    else if (kind == KIND_READ)
                    begin
                        cmd.op = OP_READ;
                    end
                    else
                    begin
                        cmd.op = OP_MOVE;
                    end
                end
                KIND_MOVE_ALL:
                begin
                    cmd.op    = OP_MOVE_ALL;
                    cmd.first = '0;
                    cmd.last  = last_addr;
                end
                KIND_FIND:
                begin
                    cmd.op    = OP_FIND;
                    cmd.first = '0;
                    cmd.last  = last_addr;
                end
                default:
                begin
                    cmd.op = OP_REPLY;
                end
            endcase
        end
    end

    assign push_data = CMD_W'(cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= SIDE_W'(1);
            rows_reg  <= SIDE_W'(1);
            ready_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && cfg_index == CFG_GRID_COLUMNS)
            begin
                cols_reg <= cfg_data;
            end
            if (cfg_write_en && cfg_index == CFG_GRID_ROWS)
            begin
                rows_reg <= cfg_data;
            end
            if (accept && kind == KIND_INIT)
            begin
                ready_reg <= 1'b1;
            end
        end
    end

endmodule

### hw/rtl/vtns_queue.sv
// Two-entry command queue between front and back ends.
module vtns_queue #(
    parameter int WIDTH = vtns_pkg::cmd_width(vtns_pkg::COORD_WIDTH_DEF,
        vtns_pkg::addr_width(vtns_pkg::table_depth(vtns_pkg::MAX_SIDE_DEF)))
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam logic [1:0] FULL = 2'd2;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = count_reg != FULL;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/vtns_back.sv
// Back end: vertex memory, scan sequencer, move and distance pipeline, result register.
module vtns_back #(
    parameter int MAX_SIDE    = vtns_pkg::MAX_SIDE_DEF,
    parameter int COORD_WIDTH = vtns_pkg::COORD_WIDTH_DEF,
    localparam int DEPTH      = vtns_pkg::table_depth(MAX_SIDE),
    localparam int AW         = vtns_pkg::addr_width(DEPTH),
    localparam int CMD_W      = vtns_pkg::cmd_width(COORD_WIDTH, AW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [CMD_W-1:0]              cmd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vtns_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic [vtns_pkg::INDEX_W-1:0]  found_index,
    output logic signed [COORD_WIDTH-1:0] read_x,
    output logic signed [COORD_WIDTH-1:0] read_y
);
    import vtns_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MAG_W = RADIUS_W;           // larger offsets always square past r*r
    localparam int WW    = (CW + 1 > MAG_W + 1) ? CW + 1 : MAG_W + 1;
    localparam int SQ_W  = 2 * MAG_W;

    typedef struct packed {
        op_t                  op;
        logic [STATUS_W-1:0]  status;
        logic [AW-1:0]        first;
        logic [AW-1:0]        last;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [RADIUS_W-1:0]  radius;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_RUN   = 3'b010,
        BK_DRAIN = 3'b100
    } back_state_t;

    // vertex storage; entries without a valid bit read as zero
    logic signed [CW-1:0] mem_x [DEPTH];
    logic signed [CW-1:0] mem_y [DEPTH];
    logic [DEPTH-1:0]     valid_reg;

    back_state_t          state_reg, state_next;
    op_t                  op_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        last_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [SQ_W-1:0]      best_reg;
    logic                 found_reg;
    logic [AW-1:0]        fidx_reg;
    logic signed [CW-1:0] rx_reg;
    logic signed [CW-1:0] ry_reg;

    // stage 1: memory read data
    logic                 p1_v_reg;
    logic [AW-1:0]        p1_idx_reg;
    logic signed [CW-1:0] rdx_reg;
    logic signed [CW-1:0] rdy_reg;
    logic                 rd_ok_reg;
    // stage 2: offset magnitudes
    logic                 p2_v_reg;
    logic [AW-1:0]        p2_idx_reg;
    logic [MAG_W-1:0]     p2_mx_reg;
    logic [MAG_W-1:0]     p2_my_reg;
    logic                 p2_far_reg;
    // stage 3: squares
    logic                 p3_v_reg;
    logic [AW-1:0]        p3_idx_reg;
    logic [SQ_W-1:0]      p3_sqx_reg;
    logic [SQ_W-1:0]      p3_sqy_reg;
    logic                 p3_far_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  res_status_reg;
    logic                 res_found_reg;
    logic [INDEX_W-1:0]   res_index_reg;
    logic signed [CW-1:0] res_x_reg;
    logic signed [CW-1:0] res_y_reg;

    cmd_t                 cmd;
    logic                 take;
    logic                 immediate;
    logic                 load_wr;
    logic                 init_clr;
    logic                 mv_wr;
    logic                 pipe_busy;
    logic                 done_scan;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [CW-1:0] wr_x;
    logic signed [CW-1:0] wr_y;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [CW:0]          mag_x;
    logic [CW:0]          mag_y;
    logic [WW-1:0]        magw_x;
    logic [WW-1:0]        magw_y;
    logic [SQ_W:0]        dist_sum;
    logic                 better;

    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        logic signed [CW-1:0] r;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1])
        begin
            r = s[CW] ? {1'b1, {(CW - 1){1'b0}}} : {1'b0, {(CW - 1){1'b1}}};
        end
        else
        begin
            r = s[CW-1:0];
        end
        return r;
    endfunction

    assign cmd       = cmd_t'(cmd_data);
    assign cmd_ready = (state_reg == BK_IDLE) && (!out_valid_reg || out_ready);
    assign take      = cmd_valid && cmd_ready;
    assign immediate = take && (cmd.op == OP_REPLY || cmd.op == OP_INIT || cmd.op == OP_LOAD);
    assign load_wr   = take && cmd.op == OP_LOAD;
    assign init_clr  = take && cmd.op == OP_INIT;
    assign pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg;
    assign done_scan = (state_reg == BK_DRAIN) && !pipe_busy;

    assign vx    = rd_ok_reg ? rdx_reg : '0;
    assign vy    = rd_ok_reg ? rdy_reg : '0;
    assign mv_wr = p1_v_reg && (op_reg == OP_MOVE || op_reg == OP_MOVE_ALL);

    always_comb
    begin
        wr_en   = load_wr || mv_wr;
        wr_addr = p1_idx_reg;
        wr_x    = sat_add(vx, cx_reg);
        wr_y    = sat_add(vy, cy_reg);
        if (load_wr)
        begin
            wr_addr = cmd.first;
            wr_x    = cmd.cx;
            wr_y    = cmd.cy;
        end
    end

    // distance path
    assign dx       = {cx_reg[CW-1], cx_reg} - {vx[CW-1], vx};
    assign dy       = {cy_reg[CW-1], cy_reg} - {vy[CW-1], vy};
    assign mag_x    = dx[CW] ? (~dx + 1'b1) : dx;
    assign mag_y    = dy[CW] ? (~dy + 1'b1) : dy;
    assign magw_x   = WW'(mag_x);
    assign magw_y   = WW'(mag_y);
    assign dist_sum = {1'b0, p3_sqx_reg} + {1'b0, p3_sqy_reg};
    assign better   = p3_v_reg && !p3_far_reg && (dist_sum < {1'b0, best_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (take && !immediate)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (immediate || done_scan)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rdx_reg   <= mem_x[addr_reg];
        rdy_reg   <= mem_y[addr_reg];
        rd_ok_reg <= valid_reg[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            state_reg     <= BK_IDLE;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (init_clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            state_reg     <= state_next;
            p1_v_reg      <= state_reg == BK_RUN;
            p2_v_reg      <= p1_v_reg && op_reg == OP_FIND;
            p3_v_reg      <= p2_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= cmd.op;
            addr_reg  <= cmd.first;
            last_reg  <= cmd.last;
            cx_reg    <= cmd.cx;
            cy_reg    <= cmd.cy;
            best_reg  <= cmd.radius * cmd.radius;
            found_reg <= 1'b0;
            fidx_reg  <= '0;
            rx_reg    <= '0;
            ry_reg    <= '0;
        end
        else
        begin
            if (state_reg == BK_RUN)
            begin
                addr_reg <= AW'(addr_reg + 1'b1);
            end
            if (p1_v_reg && op_reg == OP_READ)
            begin
                rx_reg <= vx;
                ry_reg <= vy;
            end
            if (better)
            begin
                best_reg  <= dist_sum[SQ_W-1:0];
                found_reg <= 1'b1;
                fidx_reg  <= p3_idx_reg;
            end
        end

        p1_idx_reg <= addr_reg;
        p2_idx_reg <= p1_idx_reg;
        p2_mx_reg  <= magw_x[MAG_W-1:0];
        p2_my_reg  <= magw_y[MAG_W-1:0];
        p2_far_reg <= (magw_x[WW-1:MAG_W] != '0) || (magw_y[WW-1:MAG_W] != '0);
        p3_idx_reg <= p2_idx_reg;
        p3_sqx_reg <= p2_mx_reg * p2_mx_reg;
        p3_sqy_reg <= p2_my_reg * p2_my_reg;
        p3_far_reg <= p2_far_reg;

        if (immediate)
        begin
            res_status_reg <= cmd.status;
            res_found_reg  <= 1'b0;
            res_index_reg  <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
        end
        else if (done_scan)
        begin
            res_status_reg <= ST_OK;
            res_found_reg  <= found_reg;
            res_index_reg  <= INDEX_W'(fidx_reg);
            res_x_reg      <= rx_reg;
            res_y_reg      <= ry_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign found       = res_found_reg;
    assign found_index = res_index_reg;
    assign read_x      = res_x_reg;
    assign read_y      = res_y_reg;

endmodule

### hw/rtl/vertex_table_nearest_search_unit.sv
// Top level of the vertex table with nearest-point search.
// Usage:
//  - in channel (in_valid/in_ready) carries one command item: kind, vertex_index,
//    coord_x, coord_y, search_radius. out channel (out_valid/out_ready) returns
//    exactly one result item per command, in order.
//  - cfg_write_en/cfg_index/cfg_data set grid_columns and grid_rows; write only
//    while no command is outstanding.
//  - Front end classifies each item (not ready, index range) and queues it; a
//    two-entry queue lets it keep taking items while the back end is busy.
//  - Reply-only commands, load and init: back end finishes as it takes the item,
//    the result is registered; one item per cycle sustained while out_ready is high.
//  - read and move: address issue, memory read, drain.
//  - move-all and find walk n = columns * rows in use (up to 256): the back end
//    takes one vertex per cycle through the single memory read port, then drains
//    the memory read stage (move-all) or the 3-stage distance pipeline (find).
//  - Reset: table not ready, all vertices read as zero (per-entry valid bits are
//    cleared at once), grid sizes 1. Init clears the valid bits at once.
//  - When out_ready is low the finished item holds in the output register; the
//    queue then fills and in_ready drops.
module vertex_table_nearest_search_unit #(
    parameter int MAX_SIDE    = vtns_pkg::MAX_SIDE_DEF,
    parameter int COORD_WIDTH = vtns_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [vtns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vtns_pkg::SIDE_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [vtns_pkg::KIND_W-1:0]      kind,
    input  logic [vtns_pkg::INDEX_W-1:0]     vertex_index,
    input  logic signed [COORD_WIDTH-1:0]    coord_x,
    input  logic signed [COORD_WIDTH-1:0]    coord_y,
    input  logic [vtns_pkg::RADIUS_W-1:0]    search_radius,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vtns_pkg::STATUS_W-1:0]    status,
    output logic                             found,
    output logic [vtns_pkg::INDEX_W-1:0]     found_index,
    output logic signed [COORD_WIDTH-1:0]    read_x,
    output logic signed [COORD_WIDTH-1:0]    read_y
);
    import vtns_pkg::*;

    localparam int DEPTH = table_depth(MAX_SIDE);
    localparam int AW    = addr_width(DEPTH);
    localparam int CMD_W = cmd_width(COORD_WIDTH, AW);

    // front to queue
    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_data;
    // queue to back
    logic             cmd_valid;
    logic             cmd_ready;
    logic [CMD_W-1:0] cmd_data;

    vtns_front #(
        .MAX_SIDE    (MAX_SIDE),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .vertex_index  (vertex_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .search_radius (search_radius),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    vtns_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (cmd_valid),
        .rd_ready (cmd_ready),
        .rd_data  (cmd_data)
    );

    vtns_back #(
        .MAX_SIDE    (MAX_SIDE),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .read_x      (read_x),
        .read_y      (read_y)
    );

endmodule

### verif/vertex_table_nearest_search_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the vertex table nearest-point search unit.
module vertex_table_nearest_search_unit_tb;

    import vtns_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int TABLE_SLOTS = 256;

    // kinds the block answers with a bare ok and otherwise ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

    // one result item as the block returns it
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  found;
        logic [INDEX_W-1:0]    found_index;
        logic signed [CW-1:0]  read_x;
        logic signed [CW-1:0]  read_y;
    } vertex_result_t;

    // ------------------------------------------------------------------
    // Vertex table mirror plus the queue of replies still owed by the block.
    // Commands are applied in acceptance order, so the mirror always holds
    // the table as the block should see it when the command reaches it.
    // ------------------------------------------------------------------
    class vertex_search_scoreboard;
        logic signed [CW-1:0] pos_x [TABLE_SLOTS];
        logic signed [CW-1:0] pos_y [TABLE_SLOTS];
        bit                   table_ready;
        logic [SIDE_W-1:0]    grid_columns;
        logic [SIDE_W-1:0]    grid_rows;
        vertex_result_t       owed_replies[$];
        int                   mismatches;

        function new();
            foreach (pos_x[i])
            begin
                pos_x[i] = '0;
                pos_y[i] = '0;
            end
            table_ready  = 1'b0;
            grid_columns = SIDE_W'(1);
            grid_rows    = SIDE_W'(1);
            mismatches   = 0;
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

        // counts of 0 act as 1, anything above the table side acts as the side
        function int vertex_count();
            int c;
            int r;
            c = (grid_columns == 0) ? 1 : (grid_columns > MAX_SIDE_DEF) ? MAX_SIDE_DEF
                                                                        : grid_columns;
            r = (grid_rows == 0) ? 1 : (grid_rows > MAX_SIDE_DEF) ? MAX_SIDE_DEF : grid_rows;
            return c * r;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] reg_sel, logic [SIDE_W-1:0] value);
            if (reg_sel == CFG_GRID_COLUMNS)
                grid_columns = value;
            else if (reg_sel == CFG_GRID_ROWS)
                grid_rows = value;
        endfunction

        // saturating Q8.8 add: overflow shows as the two top bits disagreeing
        function logic signed [CW-1:0] sat_sum(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b);
            logic [CW:0] s;
            s = {a[CW-1], a} + {b[CW-1], b};
            if (s[CW] != s[CW-1])
                return s[CW] ? COORD_MIN : COORD_MAX;
            return s[CW-1:0];
        endfunction

        function void note_command(logic [KIND_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                   logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                   logic [RADIUS_W-1:0] radius);
            vertex_result_t res;
            int     n;
            longint dx;
            longint dy;
            longint sq_dist;
            longint best;
            res = '0;
            n   = vertex_count();
            if (cmd == KIND_INIT)
            begin
                foreach (pos_x[i])
                begin
                    pos_x[i] = '0;
                    pos_y[i] = '0;
                end
                table_ready = 1'b1;
            end
            else if (cmd <= KIND_FIND && !table_ready)
                res.status = ST_NOT_READY;
            else if (cmd == KIND_LOAD || cmd == KIND_READ || cmd == KIND_MOVE)
            begin
                if (idx >= n)
                    res.status = ST_RANGE;
                else if (cmd == KIND_LOAD)
                begin
                    pos_x[idx] = cx;
                    pos_y[idx] = cy;
                end
                else if (cmd == KIND_READ)
                begin
                    res.read_x = pos_x[idx];
                    res.read_y = pos_y[idx];
                end
                else
                begin
                    pos_x[idx] = sat_sum(pos_x[idx], cx);
                    pos_y[idx] = sat_sum(pos_y[idx], cy);
                end
            end
            else if (cmd == KIND_MOVE_ALL)
            begin
                for (int i = 0; i < n; i++)
                begin
                    pos_x[i] = sat_sum(pos_x[i], cx);
                    pos_y[i] = sat_sum(pos_y[i], cy);
                end
            end
            else if (cmd == KIND_FIND)
            begin
                // strictly below the running best: ties keep the lower index
                best = longint'(radius) * longint'(radius);
                for (int i = 0; i < n; i++)
                begin
                    dx      = longint'(cx) - longint'(pos_x[i]);
                    dy      = longint'(cy) - longint'(pos_y[i]);
                    sq_dist = dx * dx + dy * dy;
                    if (sq_dist < best)
                    begin
                        best            = sq_dist;
                        res.found       = 1'b1;
                        res.found_index = i[INDEX_W-1:0];
                    end
                end
            end
            owed_replies.push_back(res);
        endfunction

        function void report(string what, vertex_result_t want, vertex_result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: want st %0d fnd %0d idx %0d x %0d y %0d,",
                         $realtime, what, want.status, want.found, want.found_index,
                         want.read_x, want.read_y,
                         " got st %0d fnd %0d idx %0d x %0d y %0d",
                         got.status, got.found, got.found_index, got.read_x, got.read_y);
        endfunction

        function void check_result(vertex_result_t got);
            vertex_result_t want;
            if (owed_replies.size() == 0)
            begin
                report("reply with nothing owed", '0, got);
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.found_index !== want.found_index || got.read_x !== want.read_x ||
                got.read_y !== want.read_y)
                report("reply differs", want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [SIDE_W-1:0]       cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [KIND_W-1:0]       kind;
    logic [INDEX_W-1:0]      vertex_index;
    logic signed [CW-1:0]    coord_x;
    logic signed [CW-1:0]    coord_y;
    logic [RADIUS_W-1:0]     search_radius;
    logic                    out_valid;
    logic                    out_ready;
    logic [STATUS_W-1:0]     status;
    logic                    found;
    logic [INDEX_W-1:0]      found_index;
    logic signed [CW-1:0]    read_x;
    logic signed [CW-1:0]    read_y;

    vertex_search_scoreboard sb;

    // idling controls: percent chance per item / per cycle of starting a gap
    int send_gap_pct;
    int sink_stall_pct;
    int stall_left;

    vertex_table_nearest_search_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .vertex_index  (vertex_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .search_radius (search_radius),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found         (found),
        .found_index   (found_index),
        .read_x        (read_x),
        .read_y        (read_y)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side back-pressure: random bursts with out_ready held low.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
        begin
            stall_left <= $urandom_range(0, 16);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Both handshakes are observed in one place, replies first, so a reply
    // can never be matched against the item taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
                sb.check_result('{status, found, found_index, read_x, read_y});
            if (in_valid && in_ready)
                sb.note_command(kind, vertex_index, coord_x, coord_y, search_radius);
        end
    end

    // Both grid registers are written back to back; the mirror follows on
    // the edge where each write lands.
    task automatic configure_grid(input logic [SIDE_W-1:0] columns,
                                  input logic [SIDE_W-1:0] rows);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_GRID_COLUMNS;
        cfg_data     <= columns;
        @(posedge clk);
        sb.set_register(CFG_GRID_COLUMNS, columns);
        cfg_index    <= CFG_GRID_ROWS;
        cfg_data     <= rows;
        @(posedge clk);
        sb.set_register(CFG_GRID_ROWS, rows);
        cfg_write_en <= 1'b0;
    endtask

    // Present one item, optionally after a gap, and hold it until taken.
    task automatic send_command(input logic [KIND_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                input logic [RADIUS_W-1:0] radius);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= cmd;
        vertex_index  <= idx;
        coord_x       <= x;
        coord_y       <= y;
        search_radius <= radius;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending until every owed reply is back, then let the block settle.
    // The first wait lets the item just taken reach the owed list.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly clustered values so finds land, a few rails, the rest anywhere.
    function automatic logic signed [CW-1:0] rand_coord(input int spread);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        else if (pick < 7)
            return CW'($urandom_range(0, 2 * spread) - spread);
        return CW'($urandom_range(0, (1 << CW) - 1));
    endfunction

    // Run limit, far above the slowest legal run (every item a full-table
    // walk plus the longest gap on both sides).
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int                    phase;
        int                    item;
        int                    count;
        int                    roll;
        int                    pick;
        logic [KIND_W-1:0]     cmd;
        logic [INDEX_W-1:0]    idx;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic [RADIUS_W-1:0]   radius;
        logic [SIDE_W-1:0]     columns;
        logic [SIDE_W-1:0]     rows;

        sb             = new();
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = '0;
        vertex_index   = '0;
        coord_x        = '0;
        coord_y        = '0;
        search_radius  = '0;
        out_ready      = 1'b0;
        stall_left     = 0;
        send_gap_pct   = 0;
        sink_stall_pct = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: table not yet initialised, reset grid of 1 x 1 ----
        // every command but init must answer not-ready; spare kinds answer ok
        send_command(KIND_LOAD,     8'd0, 16'sh0100, 16'sh0200, '0);
        send_command(KIND_READ,     8'd0, '0, '0, '0);
        send_command(KIND_MOVE,     8'd0, 16'sh0010, 16'sh0010, '0);
        send_command(KIND_MOVE_ALL, 8'd0, 16'sh0010, 16'sh0010, '0);
        send_command(KIND_FIND,     8'd0, '0, '0, RADIUS_MAX);
        send_command(KIND_SPARE_LO, 8'd0, '0, '0, '0);
        send_command(KIND_SPARE_HI, 8'hFF, COORD_MAX, COORD_MIN, RADIUS_MAX);
        send_command(KIND_INIT,     8'd0, '0, '0, '0);

        // saturation on both rails, out-of-range index on each indexed kind
        send_command(KIND_LOAD,     8'd0, COORD_MAX, COORD_MAX, '0);
        send_command(KIND_MOVE,     8'd0, COORD_MAX, COORD_MAX, '0);
        send_command(KIND_READ,     8'd0, '0, '0, '0);
        send_command(KIND_LOAD,     8'd1, 16'sh0100, 16'sh0100, '0);
        send_command(KIND_READ,     8'hFF, '0, '0, '0);
        send_command(KIND_MOVE,     8'd1, 16'sh0100, 16'sh0100, '0);
        send_command(KIND_MOVE_ALL, 8'd0, COORD_MIN, COORD_MIN, '0);
        send_command(KIND_MOVE_ALL, 8'd0, COORD_MIN, COORD_MIN, '0);
        send_command(KIND_READ,     8'd0, '0, '0, '0);

        // zero radius never finds; distance zero inside radius one does
        send_command(KIND_FIND,     8'd0, COORD_MIN, COORD_MIN, '0);
        send_command(KIND_FIND,     8'd0, COORD_MIN, COORD_MIN, 15'd1);

        // ---- directed: full 16 x 16 grid ----
        wait_idle();
        configure_grid(5'd16, 5'd16);
        send_command(KIND_LOAD,     8'hFF, COORD_MIN, COORD_MAX, '0);
        send_command(KIND_READ,     8'hFF, '0, '0, '0);
        send_command(KIND_LOAD,     8'd5, '0, 16'sh0A00, '0);
        // a vertex exactly on the radius is left out, the one at the probe wins
        send_command(KIND_FIND,     8'd0, '0, 16'sh0A00, 15'h0A00);
        // many vertices at the probe: the lowest index is kept
        send_command(KIND_FIND,     8'd0, '0, '0, 15'd1);

        // ---- random phases, each with its own grid and idling mix ----
        for (phase = 0; phase < 14; phase++)
        begin
            wait_idle();
            case (phase)
                0:       begin columns = 5'd1;  rows = 5'd1;  end
                1:       begin columns = 5'd16; rows = 5'd16; end
                2:       begin columns = 5'd0;  rows = 5'd0;  end
                3:       begin columns = 5'd31; rows = 5'd17; end
                4:       begin columns = 5'd16; rows = 5'd1;  end
                5:       begin columns = 5'd1;  rows = 5'd16; end
                9:
                begin
                    columns = SIDE_W'($urandom_range(0, 31));
                    rows    = SIDE_W'($urandom_range(0, 31));
                end
                default:
                begin
                    columns = SIDE_W'($urandom_range(1, 6));
                    rows    = SIDE_W'($urandom_range(1, 6));
                end
            endcase
            configure_grid(columns, rows);

            // the closing phases run without any idling
            if (phase >= 12)
            begin
                send_gap_pct   = 0;
                sink_stall_pct <= 0;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 12 : 40;
                pick = $urandom_range(0, 2);
                sink_stall_pct <= (pick == 0) ? 0 : (pick == 1) ? 4 : 20;
            end

            for (item = 0; item < 148; item++)
            begin
                count = sb.vertex_count();
                if (count == TABLE_SLOTS || $urandom_range(0, 99) < 88)
                    idx = INDEX_W'($urandom_range(0, count - 1));
                else
                    idx = INDEX_W'($urandom_range(count, TABLE_SLOTS - 1));
                x      = rand_coord(2048);
                y      = rand_coord(2048);
                radius = RADIUS_W'($urandom_range(0, RADIUS_MAX));

                roll = $urandom_range(0, 99);
                if (roll < 24)
                    cmd = KIND_LOAD;
                else if (roll < 44)
                    cmd = KIND_READ;
                else if (roll < 58)
                begin
                    cmd = KIND_MOVE;
                    x   = rand_coord(256);
                    y   = rand_coord(256);
                end
                else if (roll < 66)
                begin
                    cmd = KIND_MOVE_ALL;
                    x   = rand_coord(256);
                    y   = rand_coord(256);
                end
                else if (roll < 92)
                begin
                    cmd = KIND_FIND;
                    // probe mostly just off a stored vertex so the radius matters
                    if ($urandom_range(0, 9) < 6)
                    begin
                        pick = $urandom_range(0, count - 1);
                        x = sb.pos_x[pick] + CW'($urandom_range(0, 127)) - CW'(64);
                        y = sb.pos_y[pick] + CW'($urandom_range(0, 127)) - CW'(64);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        radius = '0;
                    else if (pick == 1)
                        radius = RADIUS_MAX;
                    else if (pick < 7)
                        radius = RADIUS_W'($urandom_range(1, 1024));
                end
                else if (roll < 94)
                    cmd = KIND_INIT;
                else if (roll < 97)
                    cmd = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
                else
                    cmd = KIND_READ;

                send_command(cmd, idx, x, y, radius);

                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
        end

        // drain, then allow a full-table walk before the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
